### rtl/siim_pkg.sv
// siim_pkg: shared types and constants of the sorted interval insert/merge block
// used by siim_front, siim_queue, siim_back and sorted_interval_insert_merge
`timescale 1ns / 1ps
`default_nettype none

package siim_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_NEW_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_NEW_HIGH = 2'd1;

  typedef logic signed [ValW-1:0] val_t;

  // results caused by one request, one or two intervals
  typedef struct packed {
    val_t a_low;
    val_t a_high;
    val_t b_low;
    val_t b_high;
    logic two;
    logic last;
  } job_t;

  typedef struct packed {
    logic merging;
    logic inserted;
  } front_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

### rtl/siim_front.sv
// siim_front: accepts list requests, holds the insert registers and merge state
// and turns each request that yields results into a job for the queue; depends on siim_pkg
`timescale 1ns / 1ps
`default_nettype none

module siim_front
  import siim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ValW-1:0]    cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_ready_q,
  input  wire val_t               in_low,
  input  wire val_t               in_high,
  input  wire logic               in_last,
  output logic                    push,
  output job_t                    push_job,
  output front_status_t           status
);

  val_t new_low;
  val_t new_high;
  logic merging;
  logic inserted;
  val_t merged_low;
  val_t merged_high;

  logic merging_next;
  logic inserted_next;
  val_t merged_low_next;
  val_t merged_high_next;
  logic accept;
  logic overlap;
  logic emit;

  assign accept  = in_valid && in_ready_q;
  assign overlap = !((in_high < new_low) || (in_low > new_high));

  always_comb begin
    merging_next     = merging;
    inserted_next    = inserted;
    merged_low_next  = merged_low;
    merged_high_next = merged_high;
    emit             = 1'b0;
    push_job         = '0;
    push_job.last    = in_last;
    if (overlap) begin
      merging_next = 1'b1;
      inserted_next = 1'b1;
      if (!merging) begin
        merged_low_next  = (in_low < new_low) ? in_low : new_low;
        merged_high_next = (in_high > new_high) ? in_high : new_high;
      end else begin
        merged_low_next  = (in_low < merged_low) ? in_low : merged_low;
        merged_high_next = (in_high > merged_high) ? in_high : merged_high;
      end
      emit            = in_last;
      push_job.a_low  = merged_low_next;
      push_job.a_high = merged_high_next;
    end else begin
      emit = 1'b1;
      priority if (merging) begin
        merging_next    = 1'b0;
        inserted_next   = 1'b1;
        push_job.a_low  = merged_low;
        push_job.a_high = merged_high;
        push_job.b_low  = in_low;
        push_job.b_high = in_high;
        push_job.two    = 1'b1;
      end else if (!inserted && (new_low < in_low)) begin
        inserted_next   = 1'b1;
        push_job.a_low  = new_low;
        push_job.a_high = new_high;
        push_job.b_low  = in_low;
        push_job.b_high = in_high;
        push_job.two    = 1'b1;
      end else begin
        push_job.a_low  = in_low;
        push_job.a_high = in_high;
        push_job.b_low  = new_low;
        push_job.b_high = new_high;
        push_job.two    = in_last && !inserted;
      end
    end
  end

  assign push            = accept && emit;
  assign status.merging  = merging;
  assign status.inserted = inserted;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_low     <= '0;
      new_high    <= '0;
      merging     <= 1'b0;
      inserted    <= 1'b0;
      merged_low  <= '0;
      merged_high <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_NEW_LOW)) begin
        new_low <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_NEW_HIGH)) begin
        new_high <= cfg_data;
      end
      if (accept) begin
        if (in_last) begin
          merging     <= 1'b0;
          inserted    <= 1'b0;
          merged_low  <= '0;
          merged_high <= '0;
        end else begin
          merging     <= merging_next;
          inserted    <= inserted_next;
          merged_low  <= merged_low_next;
          merged_high <= merged_high_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/siim_queue.sv
// siim_queue: two-entry job queue between front and back
// depends on siim_pkg
`timescale 1ns / 1ps
`default_nettype none

module siim_queue
  import siim_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire job_t     push_job,
  input  wire logic     pop,
  output job_t          head,
  output queue_status_t status
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = entry[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/siim_back.sv
// siim_back: drains jobs one result interval per cycle, while out_stall is low, into the output register
// depends on siim_pkg
`timescale 1ns / 1ps
`default_nettype none

module siim_back
  import siim_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic q_empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output val_t      out_low,
  output val_t      out_high,
  output logic      run_end,
  output logic      list_end
);

  logic idx;
  logic load;
  logic take;
  logic is_end;

  assign load   = !out_valid || !out_stall;
  assign take   = load && !q_empty;
  assign is_end = idx || !head.two;
  assign pop    = take && is_end;

  always_ff @(posedge clk) begin
    if (take) begin
      out_low  <= idx ? head.b_low : head.a_low;
      out_high <= idx ? head.b_high : head.a_high;
      run_end  <= is_end;
      list_end <= is_end && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= !q_empty;
      end
      if (take) begin
        idx <= !is_end;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sorted_interval_insert_merge.sv
// sorted_interval_insert_merge: inserts one configured interval into a streamed
// sorted interval list, merging overlaps; built from siim_front, siim_queue and
// siim_back, types from siim_pkg
//
// usage: write new_low (index 0) and new_high (index 1) on cfg_we/cfg_index/
// cfg_data while idle, then stream list intervals on in_valid/in_stall with
// in_last on the final one. a request is taken when valid is high and stall low.
// each request yields zero, one or two result intervals on out_valid/out_stall;
// run_end marks the last result of a request, list_end the last of the list.
// the front turns a request with results into a queue entry, and the back
// moves each result from that entry into the output register.
// throughput: one request per cycle while in_stall is low, one result per cycle
// on the output while out_stall is low; a two-result job pops after both results.
// the two-entry queue decouples the sides: in_stall rises only when it is full.
// out_stall holds the output register; the queue then fills and stalls input.
// reset clears the insert registers to 0, the merge state and the queue.
`timescale 1ns / 1ps
`default_nettype none

module sorted_interval_insert_merge
  import siim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ValW-1:0]    cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire val_t               in_low,
  input  wire val_t               in_high,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output val_t                    out_low,
  output val_t                    out_high,
  output logic                    run_end,
  output logic                    list_end
);

  logic          push;
  job_t          push_job;
  job_t          head;
  logic          pop;
  queue_status_t q_status;
  front_status_t f_status;

  assign in_stall = q_status.full;

  siim_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready_q (!q_status.full),
    .in_low     (in_low),
    .in_high    (in_high),
    .in_last    (in_last),
    .push       (push),
    .push_job   (push_job),
    .status     (f_status)
  );

  siim_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  siim_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_low   (out_low),
    .out_high  (out_high),
    .run_end   (run_end),
    .list_end  (list_end)
  );

  a_list_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_last) |=> (!f_status.merging && !f_status.inserted))
    else $error("merge state not cleared after list end");

  a_list_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!list_end || run_end))
    else $error("list_end without run_end");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
